@@ rtl/core/lcf_pkg.sv @@
// Package for the linear convolution FIR block.
// Holds field widths, reset values, command codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package lcf_pkg;

  localparam int MAX_TAPS_DEF     = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int RESULT_W         = 36;
  localparam int CFG_W            = 5;
  localparam int TAP_IDX_W        = 4;

  localparam logic [CFG_W-1:0] NUM_TAPS_RESET = 5'd16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_coef;
    logic push_in;
    logic push_zero;
    logic issue;
    logic clear_line;
    logic load_out;
    logic out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/lcf_datapath.sv @@
// Datapath of the linear convolution FIR block: tap count register, coefficient
// and delay line memories, one multiply-accumulate unit and the output register.
// Depends on lcf_pkg.
`default_nettype none

module lcf_datapath #(
  parameter int MAX_TAPS     = lcf_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = lcf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lcf_pkg::cmd_t                       cmd_i,
  output lcf_pkg::status_t                    status_o,
  output logic [$clog2(MAX_TAPS)-1:0]         tail_len_o,
  input  logic                                cfg_valid_i,
  input  logic [lcf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [lcf_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      value_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [lcf_pkg::RESULT_W-1:0] result_o,
  output logic                                last_of_sequence_o
);
  import lcf_pkg::*;

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int EXT_W  = (PROD_W > RESULT_W) ? PROD_W : RESULT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  logic [CFG_W-1:0] num_taps_q;
  logic [AW:0]      taps;
  logic [AW:0]      taps_m1;

  logic signed [SAMPLE_WIDTH-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]            coef_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] line_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]            line_vld_q;

  logic                           tap_ok;
  logic [AW-1:0]                  tap_addr;
  logic [AW-1:0]                  wp_q, wp_inc, rp_q, k_q;
  logic                           push;
  logic signed [SAMPLE_WIDTH-1:0] push_data;

  logic signed [SAMPLE_WIDTH-1:0] coef_rd_q, samp_rd_q;
  logic                           coef_rdv_q, samp_rdv_q;
  logic signed [SAMPLE_WIDTH-1:0] coef_op, samp_op;
  logic                           rd_v_q, prod_v_q;
  logic signed [PROD_W-1:0]       prod_d, prod_q;
  logic signed [EXT_W-1:0]        prod_ext;
  logic [RESULT_W-1:0]            acc_q;

  logic                           out_valid_q;
  logic signed [RESULT_W-1:0]     result_q;
  logic                           last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_taps_q <= NUM_TAPS_RESET;
    end else if (cfg_valid_i) begin
      num_taps_q <= cfg_data_i;
    end
  end

  // clamp tap count to 1..MAX_TAPS
  always_comb begin
    if (num_taps_q == '0) begin
      taps = (AW+1)'(1);
    end else if (32'(num_taps_q) > MAX_TAPS) begin
      taps = (AW+1)'(MAX_TAPS);
    end else begin
      taps = (AW+1)'(num_taps_q);
    end
  end

  assign taps_m1    = taps - (AW+1)'(1);
  assign tail_len_o = taps_m1[AW-1:0];

  assign tap_ok    = 32'(tap_index_i) < MAX_TAPS;
  assign tap_addr  = AW'(tap_index_i);
  assign wp_inc    = (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
  assign push      = cmd_i.push_in | cmd_i.push_zero;
  assign push_data = cmd_i.push_zero ? '0 : value_i;

  // memory arrays: write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coef && tap_ok) begin
      coef_mem[tap_addr] <= value_i;
    end
    if (push) begin
      line_mem[wp_inc] <= push_data;
    end
    if (cmd_i.issue) begin
      coef_rd_q <= coef_mem[k_q];
      samp_rd_q <= line_mem[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      line_vld_q <= '0;
      coef_rdv_q <= 1'b0;
      samp_rdv_q <= 1'b0;
      wp_q       <= '0;
      rp_q       <= '0;
      k_q        <= '0;
      rd_v_q     <= 1'b0;
      prod_v_q   <= 1'b0;
    end else begin
      rd_v_q   <= cmd_i.issue;
      prod_v_q <= rd_v_q;
      if (cmd_i.load_coef && tap_ok) begin
        coef_vld_q[tap_addr] <= 1'b1;
      end
      if (cmd_i.clear_line) begin
        line_vld_q <= '0;
      end else if (push) begin
        line_vld_q[wp_inc] <= 1'b1;
      end
      if (push) begin
        wp_q <= wp_inc;
        rp_q <= wp_inc;
        k_q  <= '0;
      end else if (cmd_i.issue) begin
        // walk back through the delay line, forward through the taps
        rp_q       <= (rp_q == '0) ? LAST_ADDR : rp_q - AW'(1);
        k_q        <= k_q + AW'(1);
        coef_rdv_q <= coef_vld_q[k_q];
        samp_rdv_q <= line_vld_q[rp_q];
      end
    end
  end

  // entries never written read as zero
  assign coef_op = coef_rdv_q ? coef_rd_q : '0;
  assign samp_op = samp_rdv_q ? samp_rd_q : '0;
  assign prod_d  = coef_op * samp_op;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_ext = EXT_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (push) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + prod_ext[RESULT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_q <= acc_q;
      last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_o           = result_q;
  assign last_of_sequence_o = last_q;

  assign status_o.last_tap  = (k_q == taps_m1[AW-1:0]);
  assign status_o.pipe_busy = rd_v_q | prod_v_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

@@ rtl/core/lcf_ctrl.sv @@
// Controller of the linear convolution FIR block: sequences loads, sample pushes,
// tap walks and tail flushes. Depends on lcf_pkg.
`default_nettype none

module lcf_ctrl #(
  parameter int MAX_TAPS = lcf_pkg::MAX_TAPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic                        end_of_sequence_i,
  input  logic [$clog2(MAX_TAPS)-1:0] tail_len_i,
  input  lcf_pkg::status_t            status_i,
  output lcf_pkg::cmd_t               cmd_o
);
  import lcf_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_MAC,
    S_DRAIN
  } state_e;

  state_e        state_q;
  logic          eos_q;
  logic [AW-1:0] rem_q;
  logic          in_acc;
  logic          done;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign done       = !status_i.pipe_busy && status_i.out_free;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_coef = in_acc && (command_i == CMD_LOAD);
        cmd_o.push_in   = in_acc && (command_i == CMD_SAMPLE);
      end
      S_PUSH: begin
        cmd_o.push_zero = 1'b1;
      end
      S_MAC: begin
        cmd_o.issue = 1'b1;
      end
      S_DRAIN: begin
        if (done) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.out_last   = eos_q && (rem_q == '0);
          // drop the delay line once the sequence is flushed
          cmd_o.clear_line = eos_q && (rem_q == '0);
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      eos_q   <= 1'b0;
      rem_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && (command_i == CMD_SAMPLE)) begin
            eos_q   <= end_of_sequence_i;
            rem_q   <= end_of_sequence_i ? tail_len_i : '0;
            state_q <= S_MAC;
          end
        end
        S_PUSH: begin
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (status_i.last_tap) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (done) begin
            if (rem_q != '0) begin
              rem_q   <= rem_q - AW'(1);
              state_q <= S_PUSH;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/linear_convolution_fir_top.sv @@
// Top level of the linear convolution FIR block.
// Instantiates lcf_ctrl and lcf_datapath; depends on lcf_pkg.
//
// Direct-form FIR convolution with one shared multiply-accumulate unit. A load word
// (command 0) writes one coefficient and leaves the input ready. A sample word
// (command 1) is pushed into a circular delay line on acceptance, and the unit then
// walks the n taps one per cycle, n being the tap count in use (num_taps clamped to
// 1..MAX_TAPS). Each tap read passes the memory read and multiply registers, and
// the sum is loaded into the output register; then the block is ready again. A
// sample flagged end_of_sequence is followed by n-1 tail results, the last one
// flagged last_of_sequence; the delay line then reads as zero. The output register
// lets the next word be accepted while a result still waits; a full
// output register stalls only the final step.
// Results are Q6.30 in 36 bits, modulo 2^36.
`default_nettype none

module linear_convolution_fir_top #(
  parameter int MAX_TAPS     = lcf_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = lcf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lcf_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [lcf_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      value_i,
  input  logic                                end_of_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lcf_pkg::RESULT_W-1:0] result_o,
  output logic                                last_of_sequence_o
);
  import lcf_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);

  cmd_t          cmd;
  status_t       status;
  logic [AW-1:0] tail_len;

  assign cfg_ready_o = 1'b1;

  lcf_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .end_of_sequence_i (end_of_sequence_i),
    .tail_len_i        (tail_len),
    .status_i          (status),
    .cmd_o             (cmd)
  );

  lcf_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .tail_len_o         (tail_len),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .tap_index_i        (tap_index_i),
    .value_i            (value_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .result_o           (result_o),
    .last_of_sequence_o (last_of_sequence_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/lcf_checker.sv @@
// Port-level assertions for the linear convolution FIR block, bound to the top level.
// Depends on lcf_pkg.
`default_nettype none

module lcf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                command_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [lcf_pkg::RESULT_W-1:0] result_o,
  input logic                                last_of_sequence_o
);
  import lcf_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o)
      && $stable(last_of_sequence_o))
    else $error("result word changed while stalled");

  // a sample word occupies the block
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_SAMPLE) |=> !in_ready_o)
    else $error("input ready right after a sample word");

  // a load word never stalls the input
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_LOAD) |=> in_ready_o)
    else $error("input stalled after a load word");

  // a load word produces no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_LOAD) && !out_valid_o
      |=> !out_valid_o)
    else $error("result word appeared after a load word");

endmodule

bind linear_convolution_fir_top lcf_checker u_lcf_checker (.*);

`default_nettype wire
